// ----- src/bf4_pkg.sv -----
// shared constants, types and helpers for the boundary fill block
package bf4_pkg;

    // frame and stack geometry
    localparam int FRAME_WIDTH  = 128;
    localparam int FRAME_HEIGHT = 128;
    localparam int STACK_DEPTH  = 16384;

    localparam int PIXELS  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int XW      = $clog2(FRAME_WIDTH);
    localparam int YW      = $clog2(FRAME_HEIGHT);
    localparam int PIX_AW  = $clog2(PIXELS);
    localparam int STK_W   = XW + YW;
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);

    // port field widths
    localparam int CMD_W   = 2;
    localparam int COORD_W = 7;
    localparam int COLOR_W = 24;
    localparam int COUNT_W = 15;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [COLOR_W-1:0] FILL_RESET  = 24'h0000FF;
    localparam logic [COLOR_W-1:0] BORDER_RESET = 24'h000000;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // register indexes
    localparam logic REG_FILL   = 1'b0;
    localparam logic REG_BORDER = 1'b1;

    localparam logic [PIX_AW-1:0] FW_A = PIX_AW'(FRAME_WIDTH);

    // linear pixel address of a column and row
    function automatic logic [PIX_AW-1:0] pix_addr(input logic [XW-1:0] xc,
                                                   input logic [YW-1:0] yc);
        pix_addr = PIX_AW'(yc) * FW_A + PIX_AW'(xc);
    endfunction

endpackage

// ----- src/bf4_ram.sv -----
// generic simple dual-port ram with registered read
module bf4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/boundary_fill_4conn_top.sv -----
// frame store with pixel write, pixel read and 4-connected boundary fill
//
// An item is taken when start is high and busy is low. Each item gives one
// result, shown for a single cycle with done high; the receiver cannot stall
// it. A write answers straight from the idle state, a read passes through
// S_RD_WAIT for the registered frame ram read. A fill is sequenced around
// the frame ram and the visit stack ram: each pop goes through a stack read,
// a frame read, then the color check, and a pixel that gets painted then
// tries its 4 neighbours in turn. Each painted pixel pushes at most 4
// neighbours. The frame ram holds FRAME_WIDTH*FRAME_HEIGHT pixels and is not
// cleared; reading a pixel that was never written gives an undefined value.
// A full stack drops the push and sets overflow for that fill. painted_count
// saturates at 32767.
module boundary_fill_4conn_top
    import bf4_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [COORD_W-1:0] x,
    input  logic [COORD_W-1:0] y,
    input  logic [COLOR_W-1:0] pixel_value,
    // result channel
    output logic               done,
    output logic [COLOR_W-1:0] read_value,
    output logic [COUNT_W-1:0] painted_count,
    output logic               overflow,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_POP,
        S_POP_WAIT,
        S_CHECK,
        S_PUSH
    } state_t;

    // neighbour order on the stack: pushed left, up, down, right
    localparam logic [1:0] NB_LEFT  = 2'd0;
    localparam logic [1:0] NB_UP    = 2'd1;
    localparam logic [1:0] NB_DOWN  = 2'd2;
    localparam logic [1:0] NB_RIGHT = 2'd3;

    localparam logic [XW-1:0] X_LAST = XW'(FRAME_WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(FRAME_HEIGHT - 1);
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

    state_t               state_reg, state_next;
    logic [SP_W-1:0]      sp_reg, sp_next;
    logic [XW-1:0]        cur_x_reg, cur_x_next;
    logic [YW-1:0]        cur_y_reg, cur_y_next;
    logic [1:0]           nb_reg, nb_next;
    logic [COUNT_W-1:0]   painted_reg, painted_next;
    logic                 ovf_reg, ovf_next;
    logic                 done_reg, done_next;
    logic [COLOR_W-1:0]   read_value_reg, read_value_next;
    logic [COUNT_W-1:0]   painted_count_reg, painted_count_next;
    logic                 overflow_reg, overflow_next;
    logic [COLOR_W-1:0]   fill_color_reg;
    logic [COLOR_W-1:0]   border_color_reg;

    // memory ports
    logic                 fr_we;
    logic [PIX_AW-1:0]    fr_waddr;
    logic [COLOR_W-1:0]   fr_wdata;
    logic [PIX_AW-1:0]    fr_raddr;
    logic [COLOR_W-1:0]   fr_rdata;
    logic                 st_we;
    logic [STK_W-1:0]     st_wdata;
    logic [STK_AW-1:0]    st_raddr;
    logic [STK_W-1:0]     st_rdata;
    logic [SP_W-1:0]      sp_dec;

    logic                 in_inside;
    logic [XW-1:0]        in_x;
    logic [YW-1:0]        in_y;
    logic [XW-1:0]        pop_x;
    logic [YW-1:0]        pop_y;
    logic                 nb_valid;
    logic [XW-1:0]        nb_x;
    logic [YW-1:0]        nb_y;
    logic                 cfg_wr;

    // input coordinates
    assign in_inside = (32'(x) < FRAME_WIDTH) && (32'(y) < FRAME_HEIGHT);
    assign in_x      = XW'(x);
    assign in_y      = YW'(y);

    // popped stack entry
    assign pop_x = st_rdata[XW-1:0];
    assign pop_y = st_rdata[STK_W-1:XW];

    // neighbour under test
    always_comb
    begin
        nb_x     = cur_x_reg;
        nb_y     = cur_y_reg;
        nb_valid = 1'b0;
        unique case (nb_reg)
            NB_LEFT:
            begin
                nb_x     = cur_x_reg - 1'b1;
                nb_valid = (cur_x_reg != '0);
            end
            NB_UP:
            begin
                nb_y     = cur_y_reg - 1'b1;
                nb_valid = (cur_y_reg != '0);
            end
            NB_DOWN:
            begin
                nb_y     = cur_y_reg + 1'b1;
                nb_valid = (cur_y_reg != Y_LAST);
            end
            NB_RIGHT:
            begin
                nb_x     = cur_x_reg + 1'b1;
                nb_valid = (cur_x_reg != X_LAST);
            end
            default:
            begin
                nb_valid = 1'b0;
            end
        endcase
    end

    // memory addressing
    assign sp_dec   = sp_reg - 1'b1;
    assign st_raddr = sp_dec[STK_AW-1:0];
    assign st_wdata = {nb_y, nb_x};
    assign fr_raddr = (state_reg == S_POP_WAIT) ? pix_addr(pop_x, pop_y)
                                                : pix_addr(in_x, in_y);
    assign fr_waddr = (state_reg == S_CHECK) ? pix_addr(cur_x_reg, cur_y_reg)
                                             : pix_addr(in_x, in_y);
    assign fr_wdata = (state_reg == S_CHECK) ? fill_color_reg : pixel_value;

    // sequencer next state
    always_comb
    begin
        state_next         = state_reg;
        sp_next            = sp_reg;
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        nb_next            = nb_reg;
        painted_next       = painted_reg;
        ovf_next           = ovf_reg;
        done_next          = 1'b0;
        read_value_next    = read_value_reg;
        painted_count_next = painted_count_reg;
        overflow_next      = overflow_reg;
        fr_we              = 1'b0;
        st_we              = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_WRITE:
                        begin
                            fr_we              = in_inside;
                            done_next          = 1'b1;
                            read_value_next    = '0;
                            painted_count_next = '0;
                            overflow_next      = 1'b0;
                        end
                        CMD_READ:
                        begin
                            if (in_inside)
                            begin
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                done_next          = 1'b1;
                                read_value_next    = '0;
                                painted_count_next = '0;
                                overflow_next      = 1'b0;
                            end
                        end
                        CMD_FILL:
                        begin
                            painted_next = '0;
                            ovf_next     = 1'b0;
                            sp_next      = '0;
                            cur_x_next   = in_x;
                            cur_y_next   = in_y;
                            if (in_inside)
                            begin
                                // seed goes straight to the check
                                state_next = S_CHECK;
                            end
                            else
                            begin
                                done_next          = 1'b1;
                                read_value_next    = '0;
                                painted_count_next = '0;
                                overflow_next      = 1'b0;
                            end
                        end
                        default:
                        begin
                            done_next          = 1'b1;
                            read_value_next    = '0;
                            painted_count_next = '0;
                            overflow_next      = 1'b0;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                done_next          = 1'b1;
                read_value_next    = fr_rdata;
                painted_count_next = '0;
                overflow_next      = 1'b0;
                state_next         = S_IDLE;
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    done_next          = 1'b1;
                    read_value_next    = '0;
                    painted_count_next = painted_reg;
                    overflow_next      = ovf_reg;
                    state_next         = S_IDLE;
                end
                else
                begin
                    sp_next    = sp_dec;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                cur_x_next = pop_x;
                cur_y_next = pop_y;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (fr_rdata == fill_color_reg || fr_rdata == border_color_reg)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    fr_we      = 1'b1;
                    nb_next    = NB_LEFT;
                    state_next = S_PUSH;
                    if (painted_reg != COUNT_MAX)
                    begin
                        painted_next = painted_reg + 1'b1;
                    end
                end
            end
            S_PUSH:
            begin
                if (nb_valid)
                begin
                    if (sp_reg == SP_FULL)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        st_we   = 1'b1;
                        sp_next = sp_reg + 1'b1;
                    end
                end
                nb_next = nb_reg + 1'b1;
                if (nb_reg == NB_RIGHT)
                begin
                    state_next = S_POP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            sp_reg            <= '0;
            done_reg          <= 1'b0;
            nb_reg            <= NB_LEFT;
            painted_reg       <= '0;
            ovf_reg           <= 1'b0;
            read_value_reg    <= '0;
            painted_count_reg <= '0;
            overflow_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            sp_reg            <= sp_next;
            done_reg          <= done_next;
            nb_reg            <= nb_next;
            painted_reg       <= painted_next;
            ovf_reg           <= ovf_next;
            read_value_reg    <= read_value_next;
            painted_count_reg <= painted_count_next;
            overflow_reg      <= overflow_next;
        end
    end

    // current pixel coordinates
    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
    end

    // configuration registers
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_color_reg   <= FILL_RESET;
            border_color_reg <= BORDER_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_FILL:   fill_color_reg   <= pwdata[COLOR_W-1:0];
                REG_BORDER: border_color_reg <= pwdata[COLOR_W-1:0];
                default:    fill_color_reg   <= fill_color_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[2])
            REG_FILL:   prdata = APB_DW'(fill_color_reg);
            REG_BORDER: prdata = APB_DW'(border_color_reg);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // frame store
    bf4_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PIXELS)
    ) u_frame (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    // visit stack
    bf4_ram #(
        .WIDTH (STK_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (sp_reg[STK_AW-1:0]),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // outputs
    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign read_value    = read_value_reg;
    assign painted_count = painted_count_reg;
    assign overflow      = overflow_reg;

endmodule

// ----- sim/boundary_fill_4conn_top_tb.sv -----
// self-checking testbench for the boundary fill frame store with command and apb ports
`timescale 1ns / 100ps

module boundary_fill_4conn_top_tb;
    import bf4_pkg::*;

    typedef logic [COLOR_W-1:0] color_t;

    // one command item with the result it should produce
    typedef struct {
        cmd_t               op;
        logic [COORD_W-1:0] xc;
        logic [COORD_W-1:0] yc;
        color_t             value;
        color_t             want_read;
        logic [COUNT_W-1:0] want_count;
        logic               want_ovf;
    } pixel_cmd_t;

    localparam int WATCHDOG_LIMIT = 600000;
    localparam int FILL_CAP       = 400;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 340;
    localparam int MAX_REPORTS    = 100;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [CMD_W-1:0]   cmd = CMD_NOP;
    logic [COORD_W-1:0] x = '0;
    logic [COORD_W-1:0] y = '0;
    color_t             pixel_value = '0;
    logic               done;
    color_t             read_value;
    logic [COUNT_W-1:0] painted_count;
    logic               overflow;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // predictor state: frame copy, scratch frame for trial fills, visit stack, colors
    color_t     frame_model [PIXELS];
    color_t     trial_frame [PIXELS];
    bit         pix_known [PIXELS];
    int         walk_stack [STACK_DEPTH];
    int         walk_sp;
    bit         walk_dropped;
    bit         walk_unknown;
    int         last_painted;
    color_t     fill_reg;
    color_t     border_reg;
    color_t     phase_bg;

    pixel_cmd_t pending_cmds[$];
    pixel_cmd_t awaiting_results[$];
    pixel_cmd_t in_flight;
    int         issued_cnt = 0;
    int         accepted_cnt = 0;
    int         mismatch_cnt = 0;
    int         quiet_cycles = 0;
    int         gap_left = 0;
    int         idle_pct = 0;
    logic       item_taken = 1'b0;

    boundary_fill_4conn_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .x             (x),
        .y             (y),
        .pixel_value   (pixel_value),
        .done          (done),
        .read_value    (read_value),
        .painted_count (painted_count),
        .overflow      (overflow),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // push onto the visit stack, a full stack drops the address
    function automatic void push_visit(input int a);
        if (walk_sp >= STACK_DEPTH)
            walk_dropped = 1'b1;
        else
        begin
            walk_stack[walk_sp] = a;
            walk_sp++;
        end
    endfunction

    // 4-connected fill on the scratch frame, returns pixels painted
    // flags the walk when it pops a pixel that was never written
    function automatic int flood_trial(input int sx, input int sy);
        int painted;
        int a;
        int px;
        int py;
        painted = 0;
        walk_sp = 0;
        walk_dropped = 1'b0;
        walk_unknown = 1'b0;
        push_visit(sy * FRAME_WIDTH + sx);
        while (walk_sp > 0)
        begin
            walk_sp--;
            a = walk_stack[walk_sp];
            if (!pix_known[a])
                walk_unknown = 1'b1;
            else if (trial_frame[a] != fill_reg && trial_frame[a] != border_reg)
            begin
                trial_frame[a] = fill_reg;
                painted++;
                px = a % FRAME_WIDTH;
                py = a / FRAME_WIDTH;
                // pushed in reverse so pops go x+1, y+1, y-1, x-1
                if (px > 0)
                    push_visit(a - 1);
                if (py > 0)
                    push_visit(a - FRAME_WIDTH);
                if (py < FRAME_HEIGHT - 1)
                    push_visit(a + FRAME_WIDTH);
                if (px < FRAME_WIDTH - 1)
                    push_visit(a + 1);
            end
        end
        return painted;
    endfunction

    // predict one item against the frame copy and queue it for the driver
    function automatic void queue_cmd(input cmd_t op, input int xc, input int yc,
                                      input color_t value);
        pixel_cmd_t c;
        int a;
        a = yc * FRAME_WIDTH + xc;
        c.op = op;
        c.xc = COORD_W'(xc);
        c.yc = COORD_W'(yc);
        c.value = value;
        c.want_read = '0;
        c.want_count = '0;
        c.want_ovf = 1'b0;
        case (op)
            CMD_WRITE:
            begin
                frame_model[a] = value;
                pix_known[a] = 1'b1;
            end
            CMD_READ:  c.want_read = frame_model[a];
            CMD_FILL:
            begin
                c.want_count = (last_painted > int'(COUNT_MAX)) ? COUNT_MAX
                                                                : COUNT_W'(last_painted);
                c.want_ovf = walk_dropped;
            end
            default: ;
        endcase
        pending_cmds.push_back(c);
        issued_cnt++;
    endfunction

    // fill item, turned into a read or a no-op when the region is too large
    // to walk cheaply or reaches a pixel that was never written
    function automatic void queue_fill(input int xc, input int yc, input int cap);
        for (int i = 0; i < PIXELS; i++)
            trial_frame[i] = frame_model[i];
        last_painted = flood_trial(xc, yc);
        if (walk_unknown || last_painted > cap)
        begin
            if (pix_known[yc * FRAME_WIDTH + xc])
                queue_cmd(CMD_READ, xc, yc, color_t'($urandom));
            else
                queue_cmd(CMD_NOP, xc, yc, color_t'($urandom));
        end
        else
        begin
            for (int i = 0; i < PIXELS; i++)
                frame_model[i] = trial_frame[i];
            queue_cmd(CMD_FILL, xc, yc, color_t'($urandom));
        end
    endfunction

    // border ring, now and then with a gap, mixed interior, a fill from a seed and some reads
    function automatic void queue_box();
        int w;
        int h;
        int ix0;
        int iy0;
        int ix1;
        int iy1;
        int sx;
        int sy;
        bit leaky;
        color_t shade;
        w = $urandom_range(6, 1);
        h = $urandom_range(6, 1);
        ix0 = $urandom_range(FRAME_WIDTH - w);
        iy0 = $urandom_range(FRAME_HEIGHT - h);
        // pull some boxes against the frame edges
        case ($urandom_range(3))
            0: ix0 = 0;
            1: ix0 = FRAME_WIDTH - w;
            default: ;
        endcase
        case ($urandom_range(3))
            0: iy0 = 0;
            1: iy0 = FRAME_HEIGHT - h;
            default: ;
        endcase
        ix1 = ix0 + w - 1;
        iy1 = iy0 + h - 1;
        leaky = ($urandom_range(7) == 0);
        // ring cells off the frame are skipped, the edge stops the fill there
        for (int yy = iy0 - 1; yy <= iy1 + 1; yy++)
            for (int xx = ix0 - 1; xx <= ix1 + 1; xx++)
                if (yy >= 0 && yy < FRAME_HEIGHT && xx >= 0 && xx < FRAME_WIDTH
                    && (yy < iy0 || yy > iy1 || xx < ix0 || xx > ix1)
                    && !(leaky && yy == iy0 && xx == ix0 - 1))
                    queue_cmd(CMD_WRITE, xx, yy, border_reg);
        for (int yy = iy0; yy <= iy1; yy++)
            for (int xx = ix0; xx <= ix1; xx++)
            begin
                case ($urandom_range(9))
                    0:       shade = border_reg;
                    1:       shade = fill_reg;
                    2, 3:    shade = color_t'($urandom);
                    default: shade = phase_bg;
                endcase
                queue_cmd(CMD_WRITE, xx, yy, shade);
            end
        // seed mostly inside, now and then on the ring
        sx = $urandom_range(ix1, ix0);
        sy = $urandom_range(iy1, iy0);
        if ($urandom_range(5) == 0 && ix0 > 0)
            sx = ix0 - 1;
        queue_fill(sx, sy, FILL_CAP);
        repeat ($urandom_range(2, 1))
            queue_cmd(CMD_READ, $urandom_range(ix1, ix0), $urandom_range(iy1, iy0),
                      color_t'($urandom));
    endfunction

    // single stray item anywhere in the frame, reads only where written
    function automatic void queue_noise();
        int rx;
        int ry;
        rx = $urandom_range(FRAME_WIDTH - 1);
        ry = $urandom_range(FRAME_HEIGHT - 1);
        case ($urandom_range(3))
            0:       queue_cmd(CMD_WRITE, rx, ry, color_t'($urandom));
            1:
            begin
                if (pix_known[ry * FRAME_WIDTH + rx])
                    queue_cmd(CMD_READ, rx, ry, color_t'($urandom));
                else
                    queue_cmd(CMD_WRITE, rx, ry, color_t'($urandom));
            end
            2:       queue_cmd(CMD_NOP, rx, ry, color_t'($urandom));
            default: queue_fill(rx, ry, FILL_CAP);
        endcase
    endfunction

    // apb setup and access cycles, returns prdata from the access cycle
    task automatic apb_access(input logic wr, input logic idx, input color_t value,
                              output logic [APB_DW-1:0] rdata);
        paddr <= {idx, 2'b00};
        pwrite <= wr;
        pwdata <= {8'($urandom), value};
        psel <= 1'b1;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // program both colors and read them back
    task automatic set_colors(input color_t f, input color_t b);
        logic [APB_DW-1:0] rd;
        apb_access(1'b1, REG_FILL, f, rd);
        apb_access(1'b1, REG_BORDER, b, rd);
        fill_reg = f;
        border_reg = b;
        apb_access(1'b0, REG_FILL, '0, rd);
        if (rd[COLOR_W-1:0] !== f)
            note_mismatch($sformatf("fill_color reads %h, wrote %h", rd[COLOR_W-1:0], f));
        apb_access(1'b0, REG_BORDER, '0, rd);
        if (rd[COLOR_W-1:0] !== b)
            note_mismatch($sformatf("border_color reads %h, wrote %h", rd[COLOR_W-1:0], b));
    endtask

    // wait until every queued item is taken and answered
    task automatic wait_idle();
        while (accepted_cnt != issued_cnt || awaiting_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // driver: hold an item until taken, otherwise idle in bursts or send the next one
    always @(negedge clk)
    begin
        if (rst_n && !(start && !item_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                if (idle_pct > 0 && $urandom_range(99) < idle_pct)
                begin
                    gap_left <= $urandom_range(13, 1) - 1;
                    start <= 1'b0;
                end
                else
                begin
                    in_flight = pending_cmds.pop_front();
                    cmd <= in_flight.op;
                    x <= in_flight.xc;
                    y <= in_flight.yc;
                    pixel_value <= in_flight.value;
                    start <= 1'b1;
                end
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check results, record taken items, watch for a stall
    always @(posedge clk)
    begin
        pixel_cmd_t w;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaiting_results.size() == 0)
                    note_mismatch($sformatf("result with no item pending: %h %0d %b",
                                            read_value, painted_count, overflow));
                else
                begin
                    w = awaiting_results.pop_front();
                    if (read_value !== w.want_read)
                        note_mismatch($sformatf("cmd %0d (%0d,%0d): read_value %h, wanted %h",
                                                w.op, w.xc, w.yc, read_value, w.want_read));
                    if (painted_count !== w.want_count)
                        note_mismatch($sformatf("cmd %0d (%0d,%0d): painted_count %0d, wanted %0d",
                                                w.op, w.xc, w.yc, painted_count, w.want_count));
                    if (overflow !== w.want_ovf)
                        note_mismatch($sformatf("cmd %0d (%0d,%0d): overflow %b, wanted %b",
                                                w.op, w.xc, w.yc, overflow, w.want_ovf));
                end
            end
            item_taken <= start && !busy;
            if (start && !busy)
            begin
                awaiting_results.push_back(in_flight);
                accepted_cnt++;
            end
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("boundary_fill_4conn_top: mismatch");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        color_t f;
        color_t b;
        int base;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        fill_reg = FILL_RESET;
        border_reg = BORDER_RESET;
        @(negedge clk);
        set_colors(24'hFFFFFF, 24'h000000);

        // corners, extreme colors, unused command, degenerate seeds,
        // a corner pixel walled in by the frame edges and two border pixels
        idle_pct = 5;
        queue_cmd(CMD_WRITE, 0, 0, 24'h000000);
        queue_cmd(CMD_WRITE, 127, 127, 24'hFFFFFF);
        queue_cmd(CMD_WRITE, 127, 0, 24'hA5A5A5);
        queue_cmd(CMD_WRITE, 0, 127, 24'h5A5A5A);
        queue_cmd(CMD_WRITE, 126, 0, 24'h000000);
        queue_cmd(CMD_WRITE, 127, 1, 24'h000000);
        queue_cmd(CMD_READ, 0, 0, 24'hFFFFFF);
        queue_cmd(CMD_READ, 127, 127, 24'h000000);
        queue_cmd(CMD_READ, 127, 0, 24'h000000);
        queue_cmd(CMD_READ, 0, 127, 24'hFFFFFF);
        queue_cmd(CMD_NOP, 127, 127, 24'hFFFFFF);
        queue_cmd(CMD_NOP, 0, 0, 24'h000000);
        queue_fill(0, 0, PIXELS);
        queue_fill(127, 127, PIXELS);
        queue_fill(127, 0, PIXELS);
        queue_cmd(CMD_READ, 127, 0, 24'h000000);
        queue_cmd(CMD_READ, 0, 0, 24'h000000);
        queue_fill(127, 0, PIXELS);

        // random phases, each under its own colors and idle rate
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    f = 24'h000000;
                    b = 24'hFFFFFF;
                end
                2:
                begin
                    // fill and border the same color
                    f = color_t'($urandom);
                    b = f;
                end
                default:
                begin
                    f = color_t'($urandom);
                    b = color_t'($urandom);
                end
            endcase
            wait_idle();
            set_colors(f, b);
            case (p)
                0:       idle_pct = 25;
                2:       idle_pct = 40;
                3:       idle_pct = 15;
                default: idle_pct = 0;
            endcase
            phase_bg = color_t'($urandom);
            base = issued_cnt;
            while (issued_cnt - base < PHASE_ITEMS)
            begin
                if ($urandom_range(4) == 0)
                    queue_noise();
                else
                    queue_box();
            end
        end

        wait_idle();
        repeat (16) @(negedge clk);
        if (mismatch_cnt == 0)
            $display("boundary_fill_4conn_top: match");
        else
            $display("boundary_fill_4conn_top: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
src/bf4_pkg.sv
src/bf4_ram.sv
src/boundary_fill_4conn_top.sv
sim/boundary_fill_4conn_top_tb.sv
